@@ src/assert_macros.svh @@
// Assertion macros shared by the coupler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/dcc_pkg.sv @@
// Types, widths and constants shared by the sign-split dual-corner coupler.
package dcc_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 24;
  localparam int TRK_FRAC       = 36;
  localparam int X_SHIFT        = TRK_FRAC - (SAMPLE_BITS - 1);
  localparam int X_W            = SAMPLE_BITS + X_SHIFT;
  localparam int TRK_W          = 40;
  localparam int DIFF_W         = TRK_W + 1;
  localparam int IND_W          = 25;
  localparam int IND_FRAC       = 24;
  localparam int COEF_W         = 25;
  localparam int DEPTH_W        = 17;
  localparam int DEPTH_FRAC     = 16;
  localparam int CURV_W         = 18;
  localparam int CURV_FRAC      = 16;
  localparam int OUT_W          = 18;
  localparam int OUT_SHIFT      = TRK_FRAC - 15;
  localparam int OUT_MAX        = 131071;
  localparam int OUT_MIN        = -131072;
  localparam int WET_W          = DIFF_W + 2;
  localparam int YP_W           = 45;
  localparam int Y_W            = 58;
  localparam int YR_SHIFT       = 18;
  localparam int YR_W           = YP_W - YR_SHIFT;
  localparam int SQ_W           = 2 * YR_W;
  localparam int ACC_W          = 76;
  localparam int B_W            = 28;
  localparam int DIG_W          = 4;
  localparam int DIG_COEF       = (COEF_W + 1) / 2;
  localparam int DIG_DEPTH      = (DEPTH_W + 1) / 2;
  localparam int DIG_SQ         = (YR_W + 1) / 2;
  localparam int DIG_CURV       = (CURV_W + 1) / 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 25;

  localparam logic [COEF_W-1:0]  COEF_ONE  = COEF_W'(1 << COEF_FRAC_BITS);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1 << DEPTH_FRAC);
  localparam logic [IND_W-1:0]   IND_ONE   = IND_W'(1 << IND_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIX_DEPTH = 3'd0,
    REG_COEF_POS  = 3'd1,
    REG_COEF_NEG  = 3'd2,
    REG_COEF_IND  = 3'd3,
    REG_CURVATURE = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_TRK_POS,
    OP_TRK_NEG,
    OP_IND,
    OP_WET,
    OP_DEPTH,
    OP_SQUARE,
    OP_CURV
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_POST,
    ST_FINISH
  } state_t;

  // Effective configuration, coefficients already limited to one.
  typedef struct packed {
    logic        [DEPTH_W-1:0] depth;
    logic        [COEF_W-1:0]  coef_pos;
    logic        [COEF_W-1:0]  coef_neg;
    logic        [COEF_W-1:0]  coef_ind;
    logic signed [CURV_W-1:0]  curv;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIG_W-1:0] digits;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

@@ src/dcc_cfg_regs.sv @@
// Configuration register file with coefficient and depth limiting.
module dcc_cfg_regs import dcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic        [DEPTH_W-1:0] mix_depth;
  logic        [COEF_W-1:0]  coef_pos;
  logic        [COEF_W-1:0]  coef_neg;
  logic        [COEF_W-1:0]  coef_ind;
  logic signed [CURV_W-1:0]  curvature;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_depth <= '0;
      coef_pos  <= '0;
      coef_neg  <= '0;
      coef_ind  <= '0;
      curvature <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIX_DEPTH: mix_depth <= cfg_data[DEPTH_W-1:0];
        REG_COEF_POS:  coef_pos  <= cfg_data[COEF_W-1:0];
        REG_COEF_NEG:  coef_neg  <= cfg_data[COEF_W-1:0];
        REG_COEF_IND:  coef_ind  <= cfg_data[COEF_W-1:0];
        REG_CURVATURE: curvature <= $signed(cfg_data[CURV_W-1:0]);
        default: ;
      endcase
    end
  end

  // Depth and coefficient values above one act as exactly one; curvature passes unchanged.
  always_comb begin
    cfg.depth    = (mix_depth > DEPTH_ONE) ? DEPTH_ONE : mix_depth;
    cfg.coef_pos = (coef_pos > COEF_ONE) ? COEF_ONE : coef_pos;
    cfg.coef_neg = (coef_neg > COEF_ONE) ? COEF_ONE : coef_neg;
    cfg.coef_ind = (coef_ind > COEF_ONE) ? COEF_ONE : coef_ind;
    cfg.curv     = curvature;
  end

endmodule

@@ src/dcc_serial_mul.sv @@
// Radix-4 shift-add multiplier: two bits of the unsigned operand per cycle.
`include "assert_macros.svh"

module dcc_serial_mul import dcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mul_req_t                req,
  input  logic signed [ACC_W-1:0] a,
  input  logic        [B_W-1:0]   b,
  output mul_stat_t               stat,
  output logic signed [ACC_W-1:0] prod
);

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] a_sh;
  logic        [B_W-1:0]   b_sh;
  logic        [DIG_W-1:0] cnt;
  logic                    busy;

  always_comb begin
    acc_next = acc + (b_sh[0] ? a_sh : '0) + (b_sh[1] ? (a_sh <<< 1) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.digits;
    end else if (busy) begin
      cnt <= cnt - DIG_W'(1);
      if (cnt == DIG_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc  <= '0;
      a_sh <= a;
      b_sh <= b;
    end else if (busy) begin
      acc  <= acc_next;
      a_sh <= a_sh <<< 2;
      b_sh <= b_sh >> 2;
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy && (cnt == DIG_W'(1));
  assign prod      = acc;

  `DCC_ASSERT_SAME(a_no_restart, req.start, !busy, "multiplier restarted while busy")
  `DCC_ASSERT_SAME(a_digits_nonzero, req.start, req.digits != '0, "zero digit count")
  `DCC_ASSERT_NEXT(a_done_ends, stat.done, !busy, "multiplier busy after done")

endmodule

@@ src/sign_split_dual_corner_coupler_core.sv @@
// Top level of the sign-split dual-corner coupler with its sequencer and datapath.
`include "assert_macros.svh"

// Sign-split dual-corner coupler. Each input item is one signed Q1.15 sample; each
// produces exactly one result item: a Q3.15 sample saturated at its range ends and a
// clipped flag. Two one-pole trackers follow the sample with separate coefficients, a
// smoothed indicator follows "sample is positive", the two high-pass signals are
// blended by that indicator, mixed with the dry sample by mix_depth, and a
// curvature*y*|y| term is added. All seven multiplications of an item run one after
// the other on a single radix-4 shift-add multiplier that retires two multiplier bits
// per cycle. Each multiplication passes through a set-up state, the digit steps and
// a write-back state, and the result is then loaded into the output register as soon
// as that register is free. The next input item can be accepted as soon as the result
// is shown, even while the result still waits in the output register. Configuration
// writes are always ready and take effect at once; write them only while the block
// holds no item in progress. Register indexes beyond the last register are ignored.
module sign_split_dual_corner_coupler_core import dcc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       sample_out,
  output logic                          clipped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam logic signed [TRK_W+1:0] TRK_HI = {3'b000, {(TRK_W-1){1'b1}}};
  localparam logic signed [TRK_W+1:0] TRK_LO = {3'b111, {(TRK_W-1){1'b0}}};
  localparam logic signed [Y_W-1:0]   Y_OUT_MAX = Y_W'(OUT_MAX);
  localparam logic signed [Y_W-1:0]   Y_OUT_MIN = Y_W'(OUT_MIN);

  cfg_t      cfg;
  mul_req_t  mreq;
  mul_stat_t mstat;

  state_t state;
  state_t state_next;
  op_t    op;
  op_t    op_next;

  // Working state of the current item and the filter state kept between items.
  logic signed [X_W-1:0]   x36;
  logic                    x_pos;
  logic signed [TRK_W-1:0] tp;
  logic signed [TRK_W-1:0] tn;
  logic        [IND_W-1:0] h;
  logic signed [WET_W-1:0] wet;
  logic signed [Y_W-1:0]   y;
  logic signed [SQ_W-1:0]  sq;

  // Multiplier operands and write-back values.
  logic signed [ACC_W-1:0]  a_sel;
  logic        [B_W-1:0]    b_sel;
  logic        [DIG_W-1:0]  dig_sel;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  prod_sh24;
  logic signed [ACC_W-1:0]  prod_sh16;
  logic signed [DIFF_W-1:0] diff_trk;
  logic signed [DIFF_W-1:0] diff_spread;
  logic signed [IND_W:0]    diff_ind;
  logic signed [YR_W-1:0]   yr;
  logic        [YR_W-1:0]   yr_mag;
  logic        [CURV_W-1:0] curv_mag;
  logic signed [SQ_W-1:0]   sq_adj;
  logic signed [TRK_W-1:0]  trk_cur;
  logic signed [TRK_W+1:0]  trk_sum;
  logic signed [TRK_W-1:0]  trk_new;
  logic signed [IND_W+1:0]  ind_sum;
  logic        [IND_W-1:0]  ind_new;
  logic signed [Y_W-1:0]    y_out;
  logic signed [OUT_W-1:0]  out_val;
  logic                     out_clip;
  logic                     accept;
  logic                     load_out;

  dcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcc_serial_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .a    (a_sel),
    .b    (b_sel),
    .stat (mstat),
    .prod (prod)
  );

  // The item is accepted only from idle; the output register is separate, so a
  // waiting result does not hold off the next sample.
  assign accept = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SETUP;
      ST_SETUP:  state_next = ST_MUL;
      ST_MUL:    if (mstat.done) state_next = ST_POST;
      ST_POST:   state_next = (op == OP_CURV) ? ST_FINISH : ST_SETUP;
      ST_FINISH: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready    = 1'b0;
    mreq.start  = 1'b0;
    mreq.digits = dig_sel;
    load_out    = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SETUP:  mreq.start = 1'b1;
      ST_MUL:    ;
      ST_POST:   ;
      ST_FINISH: load_out = !out_valid || out_ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The multiplications run in the order the arithmetic depends on them: both
  // trackers, the indicator, the high-pass blend, the depth mix, the square, and
  // finally the curvature term.
  always_comb begin
    op_next = op;
    case (op)
      OP_TRK_POS: op_next = OP_TRK_NEG;
      OP_TRK_NEG: op_next = OP_IND;
      OP_IND:     op_next = OP_WET;
      OP_WET:     op_next = OP_DEPTH;
      OP_DEPTH:   op_next = OP_SQUARE;
      OP_SQUARE:  op_next = OP_CURV;
      default:    op_next = OP_TRK_POS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_TRK_POS;
    end else if (accept) begin
      op <= OP_TRK_POS;
    end else if (state == ST_POST) begin
      op <= op_next;
    end
  end

  // Operand selection. A negative curvature is folded into the multiplicand so the
  // multiplier always sees an unsigned second operand.
  always_comb begin
    trk_cur     = (op == OP_TRK_POS) ? tp : tn;
    diff_trk    = DIFF_W'(x36) - DIFF_W'(trk_cur);
    diff_spread = DIFF_W'(tn) - DIFF_W'(tp);
    diff_ind    = (x_pos ? $signed({1'b0, IND_ONE}) : '0) - $signed({1'b0, h});
    yr          = y[YP_W-1:YR_SHIFT];
    yr_mag      = yr[YR_W-1] ? YR_W'(-yr) : YR_W'(yr);
    curv_mag    = cfg.curv[CURV_W-1] ? CURV_W'(-cfg.curv) : CURV_W'(cfg.curv);
    sq_adj      = cfg.curv[CURV_W-1] ? -sq : sq;
    a_sel       = '0;
    b_sel       = '0;
    dig_sel     = DIG_W'(DIG_COEF);
    case (op)
      OP_TRK_POS: begin
        a_sel = ACC_W'(diff_trk);
        b_sel = B_W'(cfg.coef_pos);
      end
      OP_TRK_NEG: begin
        a_sel = ACC_W'(diff_trk);
        b_sel = B_W'(cfg.coef_neg);
      end
      OP_IND: begin
        a_sel = ACC_W'(diff_ind);
        b_sel = B_W'(cfg.coef_ind);
      end
      OP_WET: begin
        a_sel = ACC_W'(diff_spread);
        b_sel = B_W'(h);
      end
      OP_DEPTH: begin
        a_sel   = ACC_W'(WET_W'(wet) - WET_W'(x36));
        b_sel   = B_W'(cfg.depth);
        dig_sel = DIG_W'(DIG_DEPTH);
      end
      OP_SQUARE: begin
        a_sel   = ACC_W'(yr);
        b_sel   = B_W'(yr_mag);
        dig_sel = DIG_W'(DIG_SQ);
      end
      default: begin
        a_sel   = ACC_W'(sq_adj);
        b_sel   = B_W'(curv_mag);
        dig_sel = DIG_W'(DIG_CURV);
      end
    endcase
  end

  // The multiplier forms the full product, so every floor is an arithmetic shift.
  always_comb begin
    prod_sh24 = prod >>> COEF_FRAC_BITS;
    prod_sh16 = prod >>> DEPTH_FRAC;
    trk_sum   = (TRK_W+2)'(trk_cur) + (TRK_W+2)'(prod_sh24);
    if (trk_sum > TRK_HI) begin
      trk_new = TRK_W'(TRK_HI);
    end else if (trk_sum < TRK_LO) begin
      trk_new = TRK_W'(TRK_LO);
    end else begin
      trk_new = TRK_W'(trk_sum);
    end
    ind_sum = $signed({2'b00, h}) + (IND_W+2)'(prod_sh24);
    if (ind_sum[IND_W+1]) begin
      ind_new = '0;
    end else if (ind_sum > $signed({2'b00, IND_ONE})) begin
      ind_new = IND_ONE;
    end else begin
      ind_new = IND_W'(ind_sum);
    end
  end

  // Filter state is control-like in that it must start from zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      tp <= '0;
      tn <= '0;
      h  <= '0;
    end else if (state == ST_POST) begin
      case (op)
        OP_TRK_POS: tp <= trk_new;
        OP_TRK_NEG: tn <= trk_new;
        OP_IND:     h  <= ind_new;
        default:    ;
      endcase
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      x36   <= {sample_in, {X_SHIFT{1'b0}}};
      x_pos <= !sample_in[SAMPLE_BITS-1] && (sample_in != '0);
    end else if (state == ST_POST) begin
      case (op)
        OP_WET:    wet <= WET_W'(x36) - WET_W'(tn) + WET_W'(prod >>> IND_FRAC);
        OP_DEPTH:  y   <= Y_W'(x36) + Y_W'(prod_sh16);
        OP_SQUARE: sq  <= SQ_W'(prod);
        OP_CURV:   y   <= y + Y_W'(prod_sh16);
        default:   ;
      endcase
    end
  end

  // Final rounding toward minus infinity to Q3.15 and saturation.
  always_comb begin
    y_out = y >>> OUT_SHIFT;
    if (y_out > Y_OUT_MAX) begin
      out_val  = OUT_W'(OUT_MAX);
      out_clip = 1'b1;
    end else if (y_out < Y_OUT_MIN) begin
      out_val  = OUT_W'(OUT_MIN);
      out_clip = 1'b1;
    end else begin
      out_val  = OUT_W'(y_out);
      out_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_out <= out_val;
      clipped    <= out_clip;
    end
  end

  `DCC_ASSERT_SAME(a_idle_mul_quiet, in_ready, !mstat.busy, "multiplier busy while idle")
  `DCC_ASSERT_SAME(a_ind_range, 1'b1, h <= IND_ONE, "indicator above one")
  `DCC_ASSERT_NEXT(a_accept_starts, accept, state == ST_SETUP && op == OP_TRK_POS,
    "accepted item did not start the sequence")

endmodule
